### sv/tms_pkg.sv
// ============================================================================
// tms_pkg
// Shared widths, request codes, note record and the built-in tone tables of
// the tone melody sequencer.
// ============================================================================
package tms_pkg;

    localparam int KIND_W    = 2;
    localparam int SFX_W     = 4;
    localparam int SPECIES_W = 10;
    localparam int HZ_W      = 13;
    localparam int MS_W      = 8;
    localparam int GAP_W     = 6;
    localparam int WAIT_W    = 9;
    localparam int SEL_W     = 4;
    localparam int POS_W     = 3;

    // Request codes
    typedef enum logic [KIND_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_SFX    = 2'd1,
        REQ_CHIRP  = 2'd2,
        REQ_ENABLE = 2'd3
    } req_kind_t;

    // Sound effects below this number are single tones
    localparam int SINGLE_COUNT = 5;

    // Chirp arithmetic
    localparam int SPECIES_MAX = 151;
    localparam int BASE_OFS    = 650;
    localparam int BASE_MUL    = 37;
    localparam int BASE_MOD    = 1150;
    localparam int STEP_OFS    = 110;
    localparam int STEP_MUL    = 17;
    localparam int STEP_MOD    = 290;
    localparam int FALL_FLOOR  = 360;
    localparam int FALL_OFS    = 280;
    localparam int SPREAD      = 80;
    localparam int SPREAD_DIV  = 5;
    // floor(x / 5) == (x * 205) >> 10 for every 8-bit x
    localparam int DIV5_MUL    = 205;
    localparam int DIV5_SHIFT  = 10;

    localparam int DEX_W      = $clog2(SPECIES_MAX + 1);
    localparam int DEX_MAX    = (1 << DEX_W) - 1;
    localparam int BASE_W     = $clog2(BASE_OFS + BASE_MOD);
    localparam int STEP_W     = $clog2(STEP_OFS + STEP_MOD);
    localparam int BASE_WRAPS = (SPECIES_MAX * BASE_MUL) / BASE_MOD;
    localparam int STEP_WRAPS = (SPECIES_MAX * STEP_MUL) / STEP_MOD;
    localparam int BASE_PW    = $clog2(DEX_MAX * BASE_MUL + 1);
    localparam int STEP_PW    = $clog2(DEX_MAX * STEP_MUL + 1);
    localparam int BASE_QW    = $clog2(BASE_WRAPS + 1);
    localparam int STEP_QW    = $clog2(STEP_WRAPS + 1);
    localparam int DIV5_PW    = $clog2(DEX_MAX * DIV5_MUL + 1);

    localparam int CHIRP_NOTES = 4;
    localparam int CHIRP_AW    = $clog2(CHIRP_NOTES);

    typedef struct packed {
        logic [HZ_W-1:0]  hz;
        logic [MS_W-1:0]  ms;
        logic [GAP_W-1:0] gap;
    } note_t;

    // Chirp seed handed to the pitch store
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [STEP_W-1:0] step;
        logic [DEX_W-1:0]  dex;
    } chirp_seed_t;

    function automatic note_t mk_note(input int hz, input int ms, input int gap);
        note_t n;
        n.hz  = HZ_W'(hz);
        n.ms  = MS_W'(ms);
        n.gap = GAP_W'(gap);
        return n;
    endfunction

    function automatic logic [POS_W-1:0] melody_len(input logic [SEL_W-1:0] sel);
        logic [POS_W-1:0] len;
        case (sel)
            4'd0:    len = 3'd4;
            4'd5:    len = 3'd4;
            4'd6:    len = 3'd6;
            4'd7:    len = 3'd4;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd3;
            4'd10:   len = 3'd3;
            4'd11:   len = 3'd3;
            4'd12:   len = 3'd5;
            4'd13:   len = 3'd4;
            4'd14:   len = 3'd2;
            4'd15:   len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic note_t melody_note(input logic [SEL_W-1:0] sel,
                                          input logic [POS_W-1:0] pos);
        note_t n;
        case ({sel, pos})
            {4'd5, 3'd0}:  n = mk_note(1050, 70, 25);
            {4'd5, 3'd1}:  n = mk_note(1350, 70, 25);
            {4'd5, 3'd2}:  n = mk_note(1750, 90, 30);
            {4'd5, 3'd3}:  n = mk_note(2350, 150, 0);
            {4'd6, 3'd0}:  n = mk_note(850, 90, 20);
            {4'd6, 3'd1}:  n = mk_note(1050, 90, 20);
            {4'd6, 3'd2}:  n = mk_note(1320, 100, 20);
            {4'd6, 3'd3}:  n = mk_note(1660, 110, 20);
            {4'd6, 3'd4}:  n = mk_note(2090, 130, 25);
            {4'd6, 3'd5}:  n = mk_note(2630, 210, 0);
            {4'd7, 3'd0}:  n = mk_note(1560, 70, 20);
            {4'd7, 3'd1}:  n = mk_note(1960, 70, 20);
            {4'd7, 3'd2}:  n = mk_note(2340, 90, 20);
            {4'd7, 3'd3}:  n = mk_note(3120, 170, 0);
            {4'd8, 3'd0}:  n = mk_note(1120, 120, 35);
            {4'd8, 3'd1}:  n = mk_note(930, 120, 35);
            {4'd8, 3'd2}:  n = mk_note(760, 150, 35);
            {4'd8, 3'd3}:  n = mk_note(560, 230, 0);
            {4'd9, 3'd0}:  n = mk_note(1500, 60, 15);
            {4'd9, 3'd1}:  n = mk_note(1950, 70, 15);
            {4'd9, 3'd2}:  n = mk_note(2600, 130, 0);
            {4'd10, 3'd0}: n = mk_note(1050, 110, 40);
            {4'd10, 3'd1}: n = mk_note(820, 130, 40);
            {4'd10, 3'd2}: n = mk_note(620, 180, 0);
            {4'd11, 3'd0}: n = mk_note(720, 80, 20);
            {4'd11, 3'd1}: n = mk_note(1040, 90, 20);
            {4'd11, 3'd2}: n = mk_note(1540, 140, 0);
            {4'd12, 3'd0}: n = mk_note(2300, 45, 18);
            {4'd12, 3'd1}: n = mk_note(2950, 45, 18);
            {4'd12, 3'd2}: n = mk_note(3600, 70, 18);
            {4'd12, 3'd3}: n = mk_note(3100, 55, 15);
            {4'd12, 3'd4}: n = mk_note(4100, 130, 0);
            {4'd13, 3'd0}: n = mk_note(1200, 60, 18);
            {4'd13, 3'd1}: n = mk_note(1600, 60, 18);
            {4'd13, 3'd2}: n = mk_note(2050, 70, 18);
            {4'd13, 3'd3}: n = mk_note(2750, 145, 0);
            {4'd14, 3'd0}: n = mk_note(2100, 45, 12);
            {4'd14, 3'd1}: n = mk_note(2850, 75, 0);
            {4'd15, 3'd0}: n = mk_note(980, 70, 20);
            {4'd15, 3'd1}: n = mk_note(1470, 70, 20);
            {4'd15, 3'd2}: n = mk_note(2200, 80, 20);
            {4'd15, 3'd3}: n = mk_note(3300, 90, 25);
            {4'd15, 3'd4}: n = mk_note(3900, 170, 0);
            default:       n = mk_note(0, 0, 0);
        endcase
        return n;
    endfunction

    // Chirp timing; pitch comes from elsewhere
    function automatic note_t chirp_note(input logic [CHIRP_AW-1:0] idx);
        note_t n;
        case (idx)
            2'd0:    n = mk_note(0, 55, 15);
            2'd1:    n = mk_note(0, 65, 15);
            2'd2:    n = mk_note(0, 55, 12);
            default: n = mk_note(0, 100, 0);
        endcase
        return n;
    endfunction

    function automatic note_t single_note(input logic [SFX_W-1:0] sfx);
        note_t n;
        case (sfx)
            4'd0:    n = mk_note(2350, 32, 0);
            4'd1:    n = mk_note(1250, 62, 0);
            4'd2:    n = mk_note(1880, 42, 0);
            4'd3:    n = mk_note(2780, 82, 0);
            4'd4:    n = mk_note(410, 115, 0);
            default: n = mk_note(0, 0, 0);
        endcase
        return n;
    endfunction

endpackage

### sv/tms_if.sv
// ============================================================================
// tms_if
// Valid/ready channels of the tone melody sequencer: request and tone result.
// ============================================================================
interface tms_req_if import tms_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    req_type;
    logic [SFX_W-1:0]     sfx_id;
    logic [SPECIES_W-1:0] species;
    logic                 enable_value;

    modport source (output valid, req_type, sfx_id, species, enable_value, input ready);
    modport sink   (input valid, req_type, sfx_id, species, enable_value, output ready);
endinterface

interface tms_tone_if import tms_pkg::*;;
    logic            valid;
    logic            ready;
    logic [HZ_W-1:0] tone_hz;
    logic [MS_W-1:0] tone_ms;
    logic            stop_all;
    logic            last_note;

    modport source (output valid, tone_hz, tone_ms, stop_all, last_note, input ready);
    modport sink   (input valid, tone_hz, tone_ms, stop_all, last_note, output ready);
endinterface

### sv/tms_pitch_calc.sv
// ============================================================================
// tms_pitch_calc
// Base and step pitch of a species chirp, by constant modulo arithmetic.
// ============================================================================
module tms_pitch_calc import tms_pkg::*;
(
    input  logic [SPECIES_W-1:0] species,
    output logic [BASE_W-1:0]    base,
    output logic [STEP_W-1:0]    step,
    output logic                 in_range
);

    logic [DEX_W-1:0]   dex;
    logic [BASE_PW-1:0] base_prod;
    logic [STEP_PW-1:0] step_prod;
    logic [BASE_QW-1:0] base_q;
    logic [STEP_QW-1:0] step_q;

    always_comb
    begin
        dex       = species[DEX_W-1:0];
        base_prod = BASE_PW'(dex) * BASE_PW'(BASE_MUL);
        step_prod = STEP_PW'(dex) * STEP_PW'(STEP_MUL);

        // quotient by parallel threshold compares
        base_q = '0;
        for (int k = 1; k <= BASE_WRAPS; k++)
        begin
            if (base_prod >= BASE_PW'(k * BASE_MOD))
                base_q = base_q + BASE_QW'(1);
        end
        step_q = '0;
        for (int k = 1; k <= STEP_WRAPS; k++)
        begin
            if (step_prod >= STEP_PW'(k * STEP_MOD))
                step_q = step_q + STEP_QW'(1);
        end

        base = BASE_W'(base_prod - BASE_PW'(base_q) * BASE_PW'(BASE_MOD))
             + BASE_W'(BASE_OFS);
        step = STEP_W'(step_prod - STEP_PW'(step_q) * STEP_PW'(STEP_MOD))
             + STEP_W'(STEP_OFS);

        in_range = (species != '0) && (species <= SPECIES_W'(SPECIES_MAX));
    end

endmodule

### sv/tms_pitch_mem.sv
// ============================================================================
// tms_pitch_mem
// Chirp pitch store: one-port-write, registered-read memory of the later
// chirp pitches, filled one entry per cycle after a chirp request.
// ============================================================================
module tms_pitch_mem import tms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  chirp_seed_t         seed,
    input  logic                rd_en,
    input  logic [CHIRP_AW-1:0] rd_addr,
    output logic [HZ_W-1:0]     rd_data
);

    logic [HZ_W-1:0]     mem [CHIRP_NOTES];
    logic [HZ_W-1:0]     rd_data_reg;
    chirp_seed_t         seed_reg;
    logic [CHIRP_AW-1:0] wr_idx_reg;
    logic [CHIRP_AW-1:0] wr_idx_next;

    logic                wr_en;
    logic [HZ_W-1:0]     wr_data;
    logic [HZ_W-1:0]     base_x;
    logic [HZ_W-1:0]     step_x;
    logic [DIV5_PW-1:0]  div5_prod;
    logic [DEX_W-1:0]    div5_q;
    logic [2:0]          rem5;
    logic                fall;
    logic [HZ_W-1:0]     p1;
    logic [HZ_W-1:0]     p2;
    logic [HZ_W-1:0]     p3;

    always_comb
    begin
        base_x    = HZ_W'(seed_reg.base);
        step_x    = HZ_W'(seed_reg.step);
        fall      = seed_reg.dex[0];
        div5_prod = DIV5_PW'(seed_reg.dex) * DIV5_PW'(DIV5_MUL);
        div5_q    = DEX_W'(div5_prod >> DIV5_SHIFT);
        rem5      = 3'(seed_reg.dex - DEX_W'(div5_q * DEX_W'(SPREAD_DIV)));

        if (fall)
            p1 = (base_x > step_x) ? (base_x - step_x) : HZ_W'(FALL_FLOOR);
        else
            p1 = base_x + step_x;
        p2 = base_x + HZ_W'(rem5) * HZ_W'(SPREAD);
        p3 = fall ? ((base_x >> 1) + HZ_W'(FALL_OFS)) : (base_x + (step_x >> 1));

        // entry 0 is the first chirp note, sent straight from the seed
        wr_en = (wr_idx_reg != '0);
        case (wr_idx_reg)
            2'd1:    wr_data = p1;
            2'd2:    wr_data = p2;
            2'd3:    wr_data = p3;
            default: wr_data = '0;
        endcase

        if (start)
            wr_idx_next = CHIRP_AW'(1);
        else if (wr_idx_reg == CHIRP_AW'(CHIRP_NOTES - 1))
            wr_idx_next = '0;
        else if (wr_en)
            wr_idx_next = wr_idx_reg + CHIRP_AW'(1);
        else
            wr_idx_next = wr_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_idx_reg <= '0;
        else
            wr_idx_reg <= wr_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            seed_reg <= seed;
        if (wr_en)
            mem[wr_idx_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/tone_melody_sequencer.sv
// ============================================================================
// tone_melody_sequencer
// Event-driven tone sequencer: ticks, sound effects, species chirps and
// enable changes in, tone start and stop transactions out.
// ============================================================================
// One request transaction is taken every cycle unless the tone sink stalls
// with both results held. A result passes through two registers: the
// request stage decides the note and issues the read of the chirp pitch
// memory, and the output register holds the finished tone. Two results can
// be held, so requests keep flowing while one result waits for the sink.
// Single tones and melody notes come from constant tables. A chirp request
// sends its first pitch at once and fills the three later pitches into the
// pitch memory; those entries are read only by ticks that come at least
// seventy requests later. A disable request always gives a stop
// transaction; ticks, sound effects and chirps while disabled give nothing.
// ============================================================================
module tone_melody_sequencer import tms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tms_req_if.sink    req,
    tms_tone_if.source tone
);

    // sequencer state
    logic               sound_on_reg, sound_on_next;
    logic               playing_reg,  playing_next;
    logic [SEL_W-1:0]   sel_reg,      sel_next;
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [WAIT_W-1:0]  wait_reg,     wait_next;

    // request stage
    logic               s1_valid_reg,   s1_valid_next;
    logic               s1_use_mem_reg, s1_use_mem_next;
    logic [HZ_W-1:0]    s1_hz_reg,      s1_hz_next;
    logic [MS_W-1:0]    s1_ms_reg,      s1_ms_next;
    logic               s1_stop_reg,    s1_stop_next;
    logic               s1_last_reg,    s1_last_next;

    // output register
    logic               out_valid_reg;
    logic [HZ_W-1:0]    out_hz_reg;
    logic [MS_W-1:0]    out_ms_reg;
    logic               out_stop_reg;
    logic               out_last_reg;

    logic               s2_load;
    logic               accept;
    logic               emit;
    logic               try_note;
    logic               chirp_start;
    logic               use_mem;
    logic [SEL_W-1:0]   e_sel;
    logic [POS_W-1:0]   e_pos;
    logic [POS_W-1:0]   e_len;
    logic [POS_W-1:0]   pos_inc;
    logic [WAIT_W-1:0]  wait_dec;
    note_t              note;
    req_kind_t          kind;

    logic [BASE_W-1:0]  chirp_base;
    logic [STEP_W-1:0]  chirp_step;
    logic               chirp_ok;
    chirp_seed_t        seed;
    logic [HZ_W-1:0]    mem_hz;

    tms_pitch_calc u_calc
    (
        .species  (req.species),
        .base     (chirp_base),
        .step     (chirp_step),
        .in_range (chirp_ok)
    );

    assign seed.base = chirp_base;
    assign seed.step = chirp_step;
    assign seed.dex  = req.species[DEX_W-1:0];

    tms_pitch_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (chirp_start),
        .seed    (seed),
        .rd_en   (emit && use_mem),
        .rd_addr (e_pos[CHIRP_AW-1:0]),
        .rd_data (mem_hz)
    );

    // handshake: request stage drains into the output register
    assign s2_load   = s1_valid_reg && (!out_valid_reg || tone.ready);
    assign req.ready = !s1_valid_reg || s2_load;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        sound_on_next = sound_on_reg;
        playing_next  = playing_reg;
        sel_next      = sel_reg;
        pos_next      = pos_reg;
        wait_next     = wait_reg;

        emit        = 1'b0;
        try_note    = 1'b0;
        chirp_start = 1'b0;
        use_mem     = 1'b0;
        e_sel       = sel_reg;
        e_pos       = pos_reg;
        e_len       = '0;
        pos_inc     = '0;
        note        = '0;
        wait_dec    = (wait_reg == '0) ? '0 : (wait_reg - WAIT_W'(1));
        kind        = req_kind_t'(req.req_type);

        s1_hz_next   = '0;
        s1_ms_next   = '0;
        s1_stop_next = 1'b0;
        s1_last_next = 1'b0;

        if (accept)
        begin
            case (kind)
                REQ_ENABLE:
                begin
                    sound_on_next = req.enable_value;
                    if (!req.enable_value)
                    begin
                        playing_next = 1'b0;
                        pos_next     = '0;
                        emit         = 1'b1;
                        s1_stop_next = 1'b1;
                    end
                end
                REQ_TICK:
                begin
                    if (sound_on_reg && playing_reg)
                    begin
                        wait_next = wait_dec;
                        try_note  = (wait_dec == '0);
                    end
                end
                REQ_SFX:
                begin
                    if (sound_on_reg)
                    begin
                        if (req.sfx_id < SFX_W'(SINGLE_COUNT))
                        begin
                            // single tone cancels any melody
                            note         = single_note(req.sfx_id);
                            playing_next = 1'b0;
                            pos_next     = '0;
                            emit         = 1'b1;
                            s1_hz_next   = note.hz;
                            s1_ms_next   = note.ms;
                            s1_last_next = 1'b1;
                        end
                        else
                        begin
                            sel_next     = req.sfx_id;
                            playing_next = 1'b1;
                            e_sel        = req.sfx_id;
                            e_pos        = '0;
                            try_note     = 1'b1;
                        end
                    end
                end
                REQ_CHIRP:
                begin
                    if (sound_on_reg && chirp_ok)
                    begin
                        sel_next     = '0;
                        playing_next = 1'b1;
                        e_sel        = '0;
                        e_pos        = '0;
                        try_note     = 1'b1;
                        chirp_start  = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // next note of the running (or just started) melody
        if (try_note)
        begin
            e_len = melody_len(e_sel);
            if (e_pos >= e_len)
            begin
                playing_next = 1'b0;
                pos_next     = '0;
            end
            else
            begin
                if (e_sel == '0)
                begin
                    note = chirp_note(e_pos[CHIRP_AW-1:0]);
                    if (chirp_start)
                        note.hz = HZ_W'(chirp_base);
                    else
                        use_mem = 1'b1;
                end
                else
                begin
                    note = melody_note(e_sel, e_pos);
                end
                emit         = 1'b1;
                pos_inc      = e_pos + POS_W'(1);
                wait_next    = WAIT_W'(note.ms) + WAIT_W'(note.gap);
                s1_hz_next   = note.hz;
                s1_ms_next   = note.ms;
                s1_last_next = (pos_inc >= e_len);
                if (pos_inc >= e_len)
                begin
                    playing_next = 1'b0;
                    pos_next     = '0;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
        end

        s1_use_mem_next = use_mem;
        if (accept)
            s1_valid_next = emit;
        else if (s2_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_on_reg  <= 1'b1;
            playing_reg   <= 1'b0;
            sel_reg       <= '0;
            pos_reg       <= '0;
            wait_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sound_on_reg <= sound_on_next;
            playing_reg  <= playing_next;
            sel_reg      <= sel_next;
            pos_reg      <= pos_next;
            wait_reg     <= wait_next;
            s1_valid_reg <= s1_valid_next;
            if (s2_load)
                out_valid_reg <= 1'b1;
            else if (tone.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_use_mem_reg <= s1_use_mem_next;
            s1_hz_reg      <= s1_hz_next;
            s1_ms_reg      <= s1_ms_next;
            s1_stop_reg    <= s1_stop_next;
            s1_last_reg    <= s1_last_next;
        end
        if (s2_load)
        begin
            out_hz_reg   <= s1_use_mem_reg ? mem_hz : s1_hz_reg;
            out_ms_reg   <= s1_ms_reg;
            out_stop_reg <= s1_stop_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign tone.valid     = out_valid_reg;
    assign tone.tone_hz   = out_hz_reg;
    assign tone.tone_ms   = out_ms_reg;
    assign tone.stop_all  = out_stop_reg;
    assign tone.last_note = out_last_reg;

endmodule
